/* hdl/byte_histogram_defines.svh */
// Assertion macros used by the byte histogram top level.
`ifndef BYTE_HISTOGRAM_DEFINES_SVH
`define BYTE_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bh_pkg.sv */
// Constants, types and helper functions for the byte histogram.
package bh_pkg;

  localparam int NUM_BINS    = 256;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int ITEM_W      = 8;
  localparam int OUT_W       = 16;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [ITEM_W:0]        BIN_LIMIT = (ITEM_W + 1)'(NUM_BINS);

  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic commit;
  } bh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic out_busy;
  } bh_sts_t;

  // A count wider than the result field saturates instead of wrapping.
  function automatic logic [OUT_W-1:0] sat_out(input logic [COUNT_WIDTH-1:0] c);
    logic [31:0] wide;
    wide = 32'(c);
    if (wide > 32'(OUT_W == 32 ? 32'hFFFF_FFFF : ((33'd1 << OUT_W) - 33'd1))) begin
      sat_out = '1;
    end else begin
      sat_out = wide[OUT_W-1:0];
    end
  endfunction

endpackage

/* hdl/bh_ctrl.sv */
// Controller state machine: takes a beat, then commits its update.
module bh_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  bh_pkg::bh_sts_t sts,
  output bh_pkg::bh_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_UPD  = 1'b1;

  logic state_r;
  logic state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd.accept = 1'b0;
    cmd.commit = 1'b0;
    state_nxt  = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_UPD;
        end
      end
      S_UPD: begin
        // A read waits until the result register can take its count.
        if (!(sts.is_read && sts.out_busy)) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/bh_datapath.sv */
// Datapath: bin memory with valid bits, update logic and result register.
module bh_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bh_pkg::bh_cmd_t          cmd,
  output bh_pkg::bh_sts_t          sts,
  input  logic                     in_kind,
  input  logic [bh_pkg::ITEM_W-1:0] in_item_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [bh_pkg::OUT_W-1:0] out_bin_count
);

  logic [bh_pkg::COUNT_WIDTH-1:0] mem [bh_pkg::NUM_BINS];
  logic [bh_pkg::NUM_BINS-1:0]    vld_r;

  logic                           kind_r;
  logic                           in_range_r;
  logic [bh_pkg::IDX_W-1:0]       idx_r;
  logic [bh_pkg::COUNT_WIDTH-1:0] rd_data_r;
  logic                           rd_vld_r;
  logic                           out_valid_r;
  logic [bh_pkg::OUT_W-1:0]       out_bin_count_r;

  logic [bh_pkg::IDX_W-1:0]       in_idx;
  logic                           in_range;
  logic [bh_pkg::COUNT_WIDTH-1:0] cur;
  logic                           do_inc;
  logic                           do_clear;

  assign in_idx   = in_item_value[bh_pkg::IDX_W-1:0];
  assign in_range = ({1'b0, in_item_value} < bh_pkg::BIN_LIMIT);

  // An entry never written since reset or since its last read holds zero.
  assign cur = (in_range_r && rd_vld_r) ? rd_data_r : '0;

  assign do_inc   = cmd.commit && (kind_r == bh_pkg::KIND_COUNT) && in_range_r &&
                    (idx_r != '0) && (cur != bh_pkg::COUNT_MAX);
  assign do_clear = cmd.commit && (kind_r == bh_pkg::KIND_READ) && in_range_r;

  assign sts.is_read  = (kind_r == bh_pkg::KIND_READ);
  assign sts.out_busy = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r     <= in_kind;
      in_range_r <= in_range;
      idx_r      <= in_idx;
      rd_data_r  <= mem[in_idx];
      rd_vld_r   <= vld_r[in_idx];
    end
    if (do_inc) begin
      mem[idx_r] <= cur + bh_pkg::COUNT_WIDTH'(1);
    end
    if (cmd.commit && sts.is_read) begin
      out_bin_count_r <= bh_pkg::sat_out(cur);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_inc) begin
        vld_r[idx_r] <= 1'b1;
      end else if (do_clear) begin
        vld_r[idx_r] <= 1'b0;
      end
      if (cmd.commit && sts.is_read) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bin_count = out_bin_count_r;

endmodule

/* hdl/byte_histogram.sv */
// Byte histogram: 256 saturating bins, counted by byte and read with clear.
//
// Input channel (in_valid / in_stall): in_kind 0 counts the byte in
// in_item_value (byte zero is ignored); in_kind 1 reads the bin named by
// in_item_value, returns its count and clears it.
// Result channel (out_valid / out_stall): one beat per read, none per count.
// A beat moves at a rising edge with valid high and stall low.
// Each accepted beat is handled in order: the bin memory read is registered at
// the accept edge, then the update is written at the commit edge, which a read
// delays while the result stalls; no new input beat is taken until it is written.
// A read result is shown from the cycle after its update edge.
// A finished result sits in the output register; while the receiver stalls,
// count beats keep completing, and a read waits in its update cycle.
// Synchronous reset (rst_n low) clears every bin at once through a valid bit
// per bin and empties the output register; no clearing pass is needed.
`include "byte_histogram_defines.svh"

module byte_histogram (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_kind,
  input  logic [bh_pkg::ITEM_W-1:0] in_item_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bh_pkg::OUT_W-1:0]  out_bin_count
);

  bh_pkg::bh_cmd_t cmd;
  bh_pkg::bh_sts_t sts;

  bh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bh_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_kind       (in_kind),
    .in_item_value (in_item_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_bin_count (out_bin_count)
  );

  `BH_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "beat not held after accept")
  `BH_ASSERT_NOW(a_result_after_update, $rose(out_valid), $past(in_stall), "result without update")
  `BH_ASSERT_NOW(a_no_overwrite, cmd.commit && sts.is_read, !(out_valid && out_stall), "result overwritten")

endmodule

/* bench/byte_histogram_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the byte histogram: counts, reads with clear and stalls.
module byte_histogram_tb;

  localparam int RUN_LIMIT    = 1_000_000;
  localparam int SETTLE_LIMIT = 8;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic                           in_kind;
  logic [bh_pkg::ITEM_W-1:0]      in_item_value;
  logic                           out_valid;
  logic                           out_stall;
  logic [bh_pkg::OUT_W-1:0]       out_bin_count;

  logic [bh_pkg::COUNT_WIDTH-1:0] bin_model [bh_pkg::NUM_BINS];
  logic [bh_pkg::OUT_W-1:0]       expected_counts [$];
  int                             error_count;
  bit                             idling;

  byte_histogram dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_item_value (in_item_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_bin_count (out_bin_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one accepted beat to the local histogram and queues any read result.
  function automatic void histogram_step(input logic kind,
                                         input logic [bh_pkg::ITEM_W-1:0] value);
    logic [63:0]              wide;
    logic [bh_pkg::OUT_W-1:0] shown;
    if (kind == bh_pkg::KIND_COUNT) begin
      if (value != '0 && int'(value) < bh_pkg::NUM_BINS &&
          bin_model[value] != bh_pkg::COUNT_MAX) begin
        bin_model[value] = bin_model[value] + 1'b1;
      end
    end else begin
      shown = '0;
      if (int'(value) < bh_pkg::NUM_BINS) begin
        wide = 64'(bin_model[value]);
        shown = ((wide >> bh_pkg::OUT_W) != 0) ? '1 : wide[bh_pkg::OUT_W-1:0];
        bin_model[value] = '0;
      end
      expected_counts.push_back(shown);
    end
  endfunction

  task automatic send_beat(input logic kind, input logic [bh_pkg::ITEM_W-1:0] value);
    @(negedge clk);
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_item_value <= value;
    do @(posedge clk); while (in_stall);
    histogram_step(kind, value);
    if (idling && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12) - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_results;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_LIMIT) @(posedge clk);
  endtask

  task automatic test_directed;
    send_beat(bh_pkg::KIND_READ, 8'd0);
    send_beat(bh_pkg::KIND_COUNT, 8'd0);
    send_beat(bh_pkg::KIND_COUNT, 8'd0);
    send_beat(bh_pkg::KIND_READ, 8'd0);
    // Repeated bins back to back exercise the read-after-update path.
    send_beat(bh_pkg::KIND_COUNT, 8'd255);
    send_beat(bh_pkg::KIND_COUNT, 8'd255);
    send_beat(bh_pkg::KIND_COUNT, 8'd255);
    send_beat(bh_pkg::KIND_COUNT, 8'd1);
    send_beat(bh_pkg::KIND_COUNT, 8'd128);
    send_beat(bh_pkg::KIND_COUNT, 8'd127);
    send_beat(bh_pkg::KIND_COUNT, 8'd127);
    send_beat(bh_pkg::KIND_READ, 8'd255);
    send_beat(bh_pkg::KIND_READ, 8'd255);
    send_beat(bh_pkg::KIND_READ, 8'd1);
    send_beat(bh_pkg::KIND_READ, 8'd128);
    send_beat(bh_pkg::KIND_READ, 8'd127);
    send_beat(bh_pkg::KIND_READ, 8'd254);
    send_beat(bh_pkg::KIND_COUNT, 8'd85);
    send_beat(bh_pkg::KIND_COUNT, 8'd170);
    send_beat(bh_pkg::KIND_COUNT, 8'd170);
    send_beat(bh_pkg::KIND_READ, 8'd170);
    send_beat(bh_pkg::KIND_READ, 8'd85);
    send_beat(bh_pkg::KIND_COUNT, 8'd1);
    send_beat(bh_pkg::KIND_READ, 8'd1);
  endtask

  // The sender holds off until every queued result has come back.
  task automatic test_pause_for_results;
    repeat (3) begin
      repeat ($urandom_range(3, 10)) begin
        send_beat(bh_pkg::KIND_COUNT, 8'($urandom_range(1, 4)));
      end
      wait_for_results();
      for (int b = 1; b <= 4; b++) send_beat(bh_pkg::KIND_READ, 8'(b));
    end
  endtask

  // Short texts over a narrow alphabet, then reads of that alphabet, with stray
  // reads and full-range bytes mixed in.
  task automatic test_text_rounds(input int item_total);
    int                        sent;
    int                        text_len;
    logic [bh_pkg::ITEM_W-1:0] base;
    logic [bh_pkg::ITEM_W-1:0] byte_val;
    sent = 0;
    while (sent < item_total) begin
      idling   = ($urandom_range(0, 3) != 0);
      base     = 8'($urandom_range(0, 255));
      text_len = $urandom_range(8, 60);
      for (int i = 0; i < text_len; i++) begin
        case ($urandom_range(0, 15))
          0:       byte_val = '0;
          1, 2, 3: byte_val = 8'($urandom_range(0, 255));
          default: byte_val = base + 8'($urandom_range(0, 7));
        endcase
        if ($urandom_range(0, 7) == 0) begin
          send_beat(bh_pkg::KIND_READ, 8'($urandom_range(0, 255)));
          sent++;
        end
        send_beat(bh_pkg::KIND_COUNT, byte_val);
        sent++;
      end
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(0, 4) != 0) begin
          send_beat(bh_pkg::KIND_READ, base + 8'(k));
          sent++;
        end
      end
    end
  endtask

  // No idling here; reading every bin leaves the store empty.
  task automatic test_final_drain;
    idling = 1'b0;
    repeat (40) send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    for (int b = 0; b < bh_pkg::NUM_BINS; b++) send_beat(bh_pkg::KIND_READ, 8'(b));
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (idling && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_counts.size() == 0) begin
        $error("bin_count: no result expected, got %0d", out_bin_count);
        error_count++;
      end else begin
        if (out_bin_count !== expected_counts[0]) begin
          $error("bin_count: expected %0d, got %0d", expected_counts[0], out_bin_count);
          error_count++;
        end
        void'(expected_counts.pop_front());
      end
    end
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = bh_pkg::KIND_COUNT;
    in_item_value = '0;
    error_count   = 0;
    idling        = 1'b1;
    for (int b = 0; b < bh_pkg::NUM_BINS; b++) bin_model[b] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_pause_for_results();
    test_text_rounds(900);
    test_final_drain();

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_LIMIT) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* byte_histogram.f */
+incdir+hdl
hdl/bh_pkg.sv
hdl/bh_ctrl.sv
hdl/bh_datapath.sv
hdl/byte_histogram.sv
bench/byte_histogram_tb.sv
